/* rtl/ats_pkg.sv */
`timescale 1ns / 1ps

package ats_pkg;

  localparam int MAX_TOK = 4;
  localparam int QDEPTH  = 4;

  localparam logic [3:0] KIND_VAR    = 4'd0;
  localparam logic [3:0] KIND_REAL   = 4'd1;
  localparam logic [3:0] KIND_COMM   = 4'd2;
  localparam logic [3:0] KIND_OPEN   = 4'd3;
  localparam logic [3:0] KIND_CLOSE  = 4'd4;
  localparam logic [3:0] KIND_ASSIGN = 4'd5;
  localparam logic [3:0] KIND_ADD    = 4'd6;
  localparam logic [3:0] KIND_SUB    = 4'd7;
  localparam logic [3:0] KIND_MUL    = 4'd8;
  localparam logic [3:0] KIND_DIV    = 4'd9;
  localparam logic [3:0] KIND_POW    = 4'd10;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_UPPERE = 8'h45;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [10:0] {
    M_IDLE = 11'b000_0000_0001,
    M_VAR  = 11'b000_0000_0010,
    M_INT  = 11'b000_0000_0100,
    M_DOT  = 11'b000_0000_1000,
    M_FRAC = 11'b000_0001_0000,
    M_EXPE = 11'b000_0010_0000,
    M_EXPM = 11'b000_0100_0000,
    M_EXPD = 11'b000_1000_0000,
    M_SP   = 11'b001_0000_0000,
    M_SPSL = 11'b010_0000_0000,
    M_COMM = 11'b100_0000_0000
  } mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [9:0]  start;
    logic [10:0] len;
  } tok_t;

  typedef struct packed {
    logic [2:0]              cnt;
    tok_t [MAX_TOK-1:0]      tok;
  } bundle_t;

endpackage

/* rtl/ats_front.sv */
`timescale 1ns / 1ps

module ats_front #(
  parameter int MAX_LINE_COLUMNS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             in_tlast,
  input  logic             q_full,
  output logic             q_push,
  output ats_pkg::bundle_t q_bundle
);

  localparam int CW = $clog2(MAX_LINE_COLUMNS + 1);
  localparam logic [CW:0] MAXC = (CW + 1)'(MAX_LINE_COLUMNS);

  typedef struct packed {
    ats_pkg::mode_t mode;
    logic [CW-1:0]  start;
    logic [CW-1:0]  marks;
    logic           ev;
    ats_pkg::tok_t  tok;
  } idle_res_t;

  ats_pkg::mode_t mode_r, mode_nxt;
  logic [CW-1:0]  start_r, start_nxt;
  logic [CW-1:0]  marks_r, marks_nxt;
  logic [CW-1:0]  col_r, col_nxt;

  logic                              fire;
  logic [7:0]                        c;
  logic [CW-1:0]                     p, se, sm, ss;
  logic                              do_idle;
  idle_res_t                         ir;
  logic [2:0]                        n;
  ats_pkg::tok_t [ats_pkg::MAX_TOK-1:0] toks;

  function automatic logic [CW-1:0] sat(input logic [CW:0] x);
    return (x < MAXC) ? x[CW-1:0] : CW'(MAX_LINE_COLUMNS - 1);
  endfunction

  function automatic logic is_letter(input logic [7:0] ch);
    return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= 8'h30 && ch <= 8'h39;
  endfunction

  function automatic ats_pkg::tok_t mk_tok(input logic [3:0] kind,
                                           input logic [CW-1:0] s,
                                           input logic [CW-1:0] e);
    ats_pkg::tok_t t;
    logic [CW-1:0] d;
    d      = (e > s) ? (e - s) : CW'(1);
    t.kind = kind;
    t.start = 10'(s);
    t.len  = 11'(d);
    return t;
  endfunction

  function automatic idle_res_t idle_fn(input logic [7:0] ch, input logic [CW-1:0] pos);
    idle_res_t r;
    r.mode  = ats_pkg::M_IDLE;
    r.start = pos;
    r.marks = pos;
    r.ev    = 1'b0;
    r.tok   = mk_tok(ats_pkg::KIND_VAR, pos, pos + CW'(1));
    if (is_letter(ch)) begin
      r.mode  = ats_pkg::M_VAR;
      r.marks = pos + CW'(1);
    end else if (is_digit(ch)) begin
      r.mode  = ats_pkg::M_INT;
      r.marks = pos + CW'(1);
    end else if (ch == ats_pkg::CH_SPACE) begin
      r.mode = ats_pkg::M_SP;
    end else begin
      r.ev = 1'b1;
      unique case (ch)
        ats_pkg::CH_LPAR:  r.tok.kind = ats_pkg::KIND_OPEN;
        ats_pkg::CH_RPAR:  r.tok.kind = ats_pkg::KIND_CLOSE;
        ats_pkg::CH_EQ:    r.tok.kind = ats_pkg::KIND_ASSIGN;
        ats_pkg::CH_PLUS:  r.tok.kind = ats_pkg::KIND_ADD;
        ats_pkg::CH_MINUS: r.tok.kind = ats_pkg::KIND_SUB;
        ats_pkg::CH_STAR:  r.tok.kind = ats_pkg::KIND_MUL;
        ats_pkg::CH_SLASH: r.tok.kind = ats_pkg::KIND_DIV;
        ats_pkg::CH_CARET: r.tok.kind = ats_pkg::KIND_POW;
        default:           r.ev = 1'b0;
      endcase
    end
    return r;
  endfunction

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    marks_nxt = marks_r;
    col_nxt   = col_r;
    n         = 3'd0;
    toks      = '0;
    do_idle   = 1'b0;
    c         = in_tlast ? ats_pkg::CH_NUL : in_tdata;
    p         = sat({1'b0, col_r});
    se        = sat({1'b0, marks_r});
    sm        = sat({1'b0, marks_r} + (CW + 1)'(1));
    ss        = sat({1'b0, start_r} + (CW + 1)'(1));
    ir        = idle_fn(c, p);

    if (in_tlast && mode_r == ats_pkg::M_COMM) begin
      toks[0] = mk_tok(ats_pkg::KIND_COMM, start_r, marks_r);
      n       = 3'd1;
    end else begin
      unique case (mode_r)
        ats_pkg::M_VAR: begin
          if (is_letter(c) || is_digit(c) || c == ats_pkg::CH_UNDER) begin
            marks_nxt = p + CW'(1);
          end else begin
            toks[n[1:0]] = mk_tok(ats_pkg::KIND_VAR, start_r, marks_r);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        ats_pkg::M_INT: begin
          if (is_digit(c)) begin
            marks_nxt = p + CW'(1);
          end else if (c == ats_pkg::CH_DOT) begin
            mode_nxt = ats_pkg::M_DOT;
          end else begin
            toks[n[1:0]] = mk_tok(ats_pkg::KIND_REAL, start_r, marks_r);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        ats_pkg::M_DOT: begin
          if (is_digit(c)) begin
            mode_nxt  = ats_pkg::M_FRAC;
            marks_nxt = p + CW'(1);
          end else begin
            toks[n[1:0]] = mk_tok(ats_pkg::KIND_REAL, start_r, marks_r);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        ats_pkg::M_FRAC, ats_pkg::M_EXPD: begin
          if (is_digit(c)) begin
            marks_nxt = p + CW'(1);
          end else if (mode_r == ats_pkg::M_FRAC && c == ats_pkg::CH_UPPERE) begin
            mode_nxt = ats_pkg::M_EXPE;
          end else begin
            toks[n[1:0]] = mk_tok(ats_pkg::KIND_REAL, start_r, marks_r);
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        ats_pkg::M_EXPE: begin
          if (is_digit(c)) begin
            mode_nxt  = ats_pkg::M_EXPD;
            marks_nxt = p + CW'(1);
          end else if (c == ats_pkg::CH_MINUS) begin
            mode_nxt = ats_pkg::M_EXPM;
          end else begin
            // back up: the E restarts as a variable
            toks[n[1:0]] = mk_tok(ats_pkg::KIND_REAL, start_r, marks_r);
            n = n + 3'd1;
            if (is_letter(c) || is_digit(c) || c == ats_pkg::CH_UNDER) begin
              mode_nxt  = ats_pkg::M_VAR;
              start_nxt = se;
              marks_nxt = p + CW'(1);
            end else begin
              toks[n[1:0]] = mk_tok(ats_pkg::KIND_VAR, se, se + CW'(1));
              n = n + 3'd1;
              do_idle = 1'b1;
            end
          end
        end
        ats_pkg::M_EXPM: begin
          if (is_digit(c)) begin
            mode_nxt  = ats_pkg::M_EXPD;
            marks_nxt = p + CW'(1);
          end else begin
            // back up: E becomes a variable, minus an operator
            toks[n[1:0]] = mk_tok(ats_pkg::KIND_REAL, start_r, marks_r);
            n = n + 3'd1;
            toks[n[1:0]] = mk_tok(ats_pkg::KIND_VAR, se, se + CW'(1));
            n = n + 3'd1;
            toks[n[1:0]] = mk_tok(ats_pkg::KIND_SUB, sm, sm + CW'(1));
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        ats_pkg::M_SP: begin
          if (c == ats_pkg::CH_SLASH) begin
            mode_nxt = ats_pkg::M_SPSL;
          end else begin
            do_idle = 1'b1;
          end
        end
        ats_pkg::M_SPSL: begin
          if (c == ats_pkg::CH_SLASH) begin
            mode_nxt  = ats_pkg::M_COMM;
            marks_nxt = p + CW'(1);
          end else begin
            toks[n[1:0]] = mk_tok(ats_pkg::KIND_DIV, ss, ss + CW'(1));
            n = n + 3'd1;
            do_idle = 1'b1;
          end
        end
        ats_pkg::M_COMM: begin
          marks_nxt = p + CW'(1);
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end

    if (do_idle) begin
      mode_nxt  = ir.mode;
      start_nxt = ir.start;
      marks_nxt = ir.marks;
      if (ir.ev) begin
        toks[n[1:0]] = ir.tok;
        n = n + 3'd1;
      end
    end

    if (in_tlast) begin
      mode_nxt  = ats_pkg::M_IDLE;
      start_nxt = '0;
      marks_nxt = '0;
      col_nxt   = '0;
    end else if ({1'b0, col_r} < MAXC) begin
      col_nxt = col_r + CW'(1);
    end
  end

  assign q_push       = fire && (n != 3'd0);
  assign q_bundle.cnt = n;
  assign q_bundle.tok = toks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ats_pkg::M_IDLE;
      start_r <= '0;
      marks_r <= '0;
      col_r   <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      marks_r <= marks_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

/* rtl/ats_queue.sv */
`timescale 1ns / 1ps

module ats_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ats_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output ats_pkg::bundle_t head_data
);

  localparam int PW = $clog2(ats_pkg::QDEPTH);
  localparam int NW = $clog2(ats_pkg::QDEPTH + 1);

  ats_pkg::bundle_t mem_r [ats_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    cnt_r;

  assign full       = cnt_r == NW'(ats_pkg::QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("bundle written into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !head_valid |-> !pop)
    else $error("bundle read from empty queue");

endmodule

/* rtl/ats_back.sv */
`timescale 1ns / 1ps

module ats_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  ats_pkg::bundle_t head_data,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [23:0]      out_tdata,
  output logic [3:0]       out_tuser,
  output logic             out_tlast
);

  logic [1:0]    idx_r;
  logic [1:0]    idx_nxt;
  logic          valid_r;
  logic          last_r;
  ats_pkg::tok_t tok_r;
  logic          load;
  logic          is_last;

  assign load    = head_valid && (!valid_r || out_tready);
  assign is_last = {1'b0, idx_r} == (head_data.cnt - 3'd1);
  assign pop     = load && is_last;
  assign idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= idx_nxt;
      end
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= head_data.tok[idx_r];
      last_r <= is_last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {3'b000, tok_r.len, tok_r.start};
  assign out_tuser  = tok_r.kind;
  assign out_tlast  = last_r;

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_tvalid && out_tlast)
    else $error("bundle retired without its last beat");
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> ({1'b0, idx_r} < head_data.cnt))
    else $error("token index past bundle count");

endmodule

/* rtl/arithmetic_token_scanner.sv */
// A character's first token is stored in the bundle queue, then in the output register.
// Throughput: 1 character per cycle; tokens leave at 1 per cycle while out_tready is high.
// A character may yield up to 4 tokens; input stalls only while the 4-entry queue is full.
// Reset (rst_n low, synchronous): scanner idle at column 0, queue empty, no output valid.
`timescale 1ns / 1ps

module arithmetic_token_scanner #(
  parameter int MAX_LINE_COLUMNS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [9:0] start_column, [20:10] token_length, [23:21] zero
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // last_of_run
);

  logic             q_full;
  logic             q_push;
  ats_pkg::bundle_t q_wdata;
  logic             q_pop;
  logic             q_valid;
  ats_pkg::bundle_t q_head;

  ats_front #(
    .MAX_LINE_COLUMNS(MAX_LINE_COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tlast (in_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_bundle (q_wdata)
  );

  ats_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_data (q_head)
  );

  ats_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_valid),
    .head_data (q_head),
    .pop       (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

/* dv/scanner_checker.sv */
`timescale 1ns / 1ps

module scanner_checker #(
  parameter int MAX_LINE_COLUMNS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic [3:0]  kind;
    logic [9:0]  start;
    logic [10:0] len;
    logic        last;
  } token_rec_t;

  token_rec_t expected_tokens[$];
  token_rec_t step_tokens[$];

  ats_pkg::mode_t scan_st;
  int    tok_begin;
  int    tok_end;
  int    col_count;
  int    err_count = 0;

  assign fail_count = err_count;

  function automatic int clamp_col(int c);
    return (c < MAX_LINE_COLUMNS) ? c : MAX_LINE_COLUMNS - 1;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic void push_token(logic [3:0] kind, int col_lo, int col_hi);
    token_rec_t t;
    if (step_tokens.size() >= ats_pkg::MAX_TOK) return;
    t.kind  = kind;
    t.start = 10'(col_lo);
    t.len   = 11'((col_hi > col_lo) ? col_hi - col_lo : 1);
    t.last  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void open_token(ats_pkg::mode_t m, int p);
    scan_st   = m;
    tok_begin = p;
    tok_end   = p + 1;
  endfunction

  function automatic void start_at(logic [7:0] c, int p);
    scan_st = ats_pkg::M_IDLE;
    if (is_letter(c)) begin
      open_token(ats_pkg::M_VAR, p);
    end else if (is_digit(c)) begin
      open_token(ats_pkg::M_INT, p);
    end else if (c == ats_pkg::CH_SPACE) begin
      scan_st   = ats_pkg::M_SP;
      tok_begin = p;
      tok_end   = p;
    end else begin
      case (c)
        ats_pkg::CH_LPAR:  push_token(ats_pkg::KIND_OPEN, p, p + 1);
        ats_pkg::CH_RPAR:  push_token(ats_pkg::KIND_CLOSE, p, p + 1);
        ats_pkg::CH_EQ:    push_token(ats_pkg::KIND_ASSIGN, p, p + 1);
        ats_pkg::CH_PLUS:  push_token(ats_pkg::KIND_ADD, p, p + 1);
        ats_pkg::CH_MINUS: push_token(ats_pkg::KIND_SUB, p, p + 1);
        ats_pkg::CH_STAR:  push_token(ats_pkg::KIND_MUL, p, p + 1);
        ats_pkg::CH_SLASH: push_token(ats_pkg::KIND_DIV, p, p + 1);
        ats_pkg::CH_CARET: push_token(ats_pkg::KIND_POW, p, p + 1);
        default: ;
      endcase
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c, int p);
    int e;
    bit minus_seen;
    e = tok_end;
    case (scan_st)
      ats_pkg::M_VAR: begin
        if (is_letter(c) || is_digit(c) || c == ats_pkg::CH_UNDER) begin
          tok_end = p + 1;
        end else begin
          push_token(ats_pkg::KIND_VAR, tok_begin, e);
          start_at(c, p);
        end
      end
      ats_pkg::M_INT: begin
        if (is_digit(c)) begin
          tok_end = p + 1;
        end else if (c == ats_pkg::CH_DOT) begin
          scan_st = ats_pkg::M_DOT;
        end else begin
          push_token(ats_pkg::KIND_REAL, tok_begin, e);
          start_at(c, p);
        end
      end
      ats_pkg::M_DOT: begin
        if (is_digit(c)) begin
          scan_st = ats_pkg::M_FRAC;
          tok_end = p + 1;
        end else begin
          push_token(ats_pkg::KIND_REAL, tok_begin, e);
          start_at(c, p);
        end
      end
      ats_pkg::M_FRAC, ats_pkg::M_EXPD: begin
        if (is_digit(c)) begin
          tok_end = p + 1;
        end else if (scan_st == ats_pkg::M_FRAC && c == ats_pkg::CH_UPPERE) begin
          scan_st = ats_pkg::M_EXPE;
        end else begin
          push_token(ats_pkg::KIND_REAL, tok_begin, e);
          start_at(c, p);
        end
      end
      ats_pkg::M_EXPE, ats_pkg::M_EXPM: begin
        if (is_digit(c)) begin
          scan_st = ats_pkg::M_EXPD;
          tok_end = p + 1;
        end else if (scan_st == ats_pkg::M_EXPE && c == ats_pkg::CH_MINUS) begin
          scan_st = ats_pkg::M_EXPM;
        end else begin
          // exponent failed: rescan the pending E and minus
          minus_seen = (scan_st == ats_pkg::M_EXPM);
          push_token(ats_pkg::KIND_REAL, tok_begin, e);
          start_at(ats_pkg::CH_UPPERE, clamp_col(e));
          if (minus_seen) scan_byte(ats_pkg::CH_MINUS, clamp_col(e + 1));
          scan_byte(c, p);
        end
      end
      ats_pkg::M_SP: begin
        if (c == ats_pkg::CH_SLASH) scan_st = ats_pkg::M_SPSL;
        else start_at(c, p);
      end
      ats_pkg::M_SPSL: begin
        if (c == ats_pkg::CH_SLASH) begin
          scan_st = ats_pkg::M_COMM;
          tok_end = p + 1;
        end else begin
          start_at(ats_pkg::CH_SLASH, clamp_col(tok_begin + 1));
          scan_byte(c, p);
        end
      end
      ats_pkg::M_COMM: tok_end = p + 1;
      default: start_at(c, p);
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] c, logic eol);
    step_tokens.delete();
    if (eol) begin
      if (scan_st == ats_pkg::M_COMM) push_token(ats_pkg::KIND_COMM, tok_begin, tok_end);
      else scan_byte(ats_pkg::CH_NUL, clamp_col(col_count));
      scan_st   = ats_pkg::M_IDLE;
      tok_begin = 0;
      tok_end   = 0;
      col_count = 0;
    end else begin
      scan_byte(c, clamp_col(col_count));
      if (col_count < MAX_LINE_COLUMNS) col_count++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  always @(posedge clk) begin
    token_rec_t want;
    if (!rst_n) begin
      scan_st   = ats_pkg::M_IDLE;
      tok_begin = 0;
      tok_end   = 0;
      col_count = 0;
      expected_tokens.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_tokens.size() == 0) begin
          $error("token with none expected: kind %0d start %0d len %0d",
                 out_tuser, out_tdata[9:0], out_tdata[20:10]);
          err_count++;
        end else begin
          want = expected_tokens.pop_front();
          if (out_tuser !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, out_tuser);
            err_count++;
          end
          if (out_tdata[9:0] !== want.start) begin
            $error("start_column: expected %0d, got %0d", want.start, out_tdata[9:0]);
            err_count++;
          end
          if (out_tdata[20:10] !== want.len) begin
            $error("token_length: expected %0d, got %0d", want.len, out_tdata[20:10]);
            err_count++;
          end
          if (out_tdata[23:21] !== 3'd0) begin
            $error("tdata pad: expected 0, got %0d", out_tdata[23:21]);
            err_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_tlast);
            err_count++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_tokens(in_tdata, in_tlast);
    end
    pending <= expected_tokens.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int         CYCLE_LIMIT = 400000;
  localparam int         PHASE_BEATS = 70;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_LOW_A    = 8'h61;
  localparam logic [7:0] CH_UP_A     = 8'h41;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  int beats_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  logic [7:0] line_buf[$];

  arithmetic_token_scanner u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  scanner_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_left = 80;
        hold_ack  = hold_req;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? CH_LOW_A + 8'(r) : CH_UP_A + 8'(r - 26);
  endfunction

  function automatic logic [7:0] rand_ident_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return rand_letter();
    if (r < 9) return rand_digit();
    return ats_pkg::CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 7))
      0: return ats_pkg::CH_LPAR;
      1: return ats_pkg::CH_RPAR;
      2: return ats_pkg::CH_EQ;
      3: return ats_pkg::CH_PLUS;
      4: return ats_pkg::CH_MINUS;
      5: return ats_pkg::CH_STAR;
      6: return ats_pkg::CH_SLASH;
      default: return ats_pkg::CH_CARET;
    endcase
  endfunction

  // random byte that is neither a digit nor the given character
  function automatic logic [7:0] rand_breaker(logic [7:0] avoid);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_ZERO && c <= CH_ZERO + 8'd9) || c == avoid);
    return c;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(8'(s[i]));
  endfunction

  function automatic void add_digits(int lo, int hi);
    repeat ($urandom_range(lo, hi)) line_buf.push_back(rand_digit());
  endfunction

  function automatic void add_fragment();
    bit minus;
    case ($urandom_range(0, 13))
      0, 1, 2: begin
        line_buf.push_back(rand_letter());
        repeat ($urandom_range(0, 5)) line_buf.push_back(rand_ident_char());
      end
      3, 4, 5: begin
        add_digits(1, 3);
        if ($urandom_range(0, 2) != 0) begin
          line_buf.push_back(ats_pkg::CH_DOT);
          add_digits(1, 3);
          if ($urandom_range(0, 1) != 0) begin
            line_buf.push_back(ats_pkg::CH_UPPERE);
            if ($urandom_range(0, 1) != 0) line_buf.push_back(ats_pkg::CH_MINUS);
            add_digits(1, 2);
          end
        end
      end
      6, 7, 8: line_buf.push_back(rand_operator());
      9: repeat ($urandom_range(1, 2)) line_buf.push_back(ats_pkg::CH_SPACE);
      10: begin
        add_digits(1, 2);
        line_buf.push_back(ats_pkg::CH_DOT);
        line_buf.push_back(rand_breaker(ats_pkg::CH_DOT));
      end
      11: begin
        add_digits(1, 2);
        line_buf.push_back(ats_pkg::CH_DOT);
        add_digits(1, 2);
        line_buf.push_back(ats_pkg::CH_UPPERE);
        minus = $urandom_range(0, 1);
        if (minus) line_buf.push_back(ats_pkg::CH_MINUS);
        line_buf.push_back(minus ? rand_breaker(ats_pkg::CH_DOT)
                                 : rand_breaker(ats_pkg::CH_MINUS));
      end
      12: begin
        line_buf.push_back(ats_pkg::CH_SPACE);
        line_buf.push_back(ats_pkg::CH_SLASH);
        line_buf.push_back(rand_breaker(ats_pkg::CH_SLASH));
      end
      default: line_buf.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  function automatic void build_line();
    repeat ($urandom_range(1, 8)) add_fragment();
    if ($urandom_range(0, 3) == 0) begin
      add_text(" //");
      repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_beat(input logic [7:0] c, input logic eol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eol;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(input logic [7:0] eol_code);
    foreach (line_buf[i]) send_beat(line_buf[i], 1'b0);
    send_beat(eol_code, 1'b1);
    line_buf.delete();
  endtask

  initial begin
    int base;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // operators = - ^ / (, failed exponent with minus, failed comment
    add_text("a_Z9=1.5E-^ /(");
    send_line(8'hA5);
    // failed fraction, exponent, comment body with CR and extreme bytes
    add_text("3.)*+1.5E7 //");
    line_buf.push_back(8'h0D);
    line_buf.push_back(8'hFF);
    line_buf.push_back(ats_pkg::CH_NUL);
    send_line(8'hFF);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      // long receiver hold-off while tokens keep coming
      if (phase == 0) hold_req++;
      base = beats_sent;
      while (beats_sent - base < PHASE_BEATS) begin
        build_line();
        send_line(8'($urandom_range(0, 255)));
      end
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
